// ----- rtl/gbn_pkg.sv -----
// gbn_pkg: codes and fixed widths for the go-back-n state table
// used by gbn_outq and go_back_n_state_table_top; no dependencies
package gbn_pkg;

  localparam int FUNC_W = 3;
  localparam int TYPE_W = 3;
  localparam int KIND_W = 3;
  localparam int IP_W   = 32;
  localparam int WIN_W  = 16;

  localparam logic [WIN_W-1:0] WIN_RESET = 16'd16;

  // item functions
  localparam logic [FUNC_W-1:0] FUNC_RX        = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEND_REQ  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEND_DONE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TIMEOUT   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_INIT      = 3'd4;

  // received packet types
  localparam logic [TYPE_W-1:0] PKT_DATA = 3'd0;
  localparam logic [TYPE_W-1:0] PKT_ACK  = 3'd1;
  localparam logic [TYPE_W-1:0] PKT_NACK = 3'd2;
  localparam logic [TYPE_W-1:0] PKT_SYN  = 3'd3;
  localparam logic [TYPE_W-1:0] PKT_FIN  = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TIMER   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RETRANS = 3'd3;
  localparam logic [KIND_W-1:0] KIND_GRANT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REFUSE  = 3'd5;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

endpackage

// ----- rtl/gbn_outq.sv -----
// gbn_outq: four-entry result queue, up to two pushes per cycle, one pop
// depends on gbn_pkg for the queue depth and pointer widths
module gbn_outq import gbn_pkg::*; #(
  parameter int W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_n,
  input  logic [W-1:0]       push_d0,
  input  logic [W-1:0]       push_d1,
  output logic [W-1:0]       head,
  output logic               head_valid,
  input  logic               pop,
  output logic [Q_CNT_W-1:0] count
);

  logic [W-1:0]       q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign count      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(do_pop);
    cnt_nxt    = cnt_r + Q_CNT_W'(push_n) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= push_d0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + Q_PTR_W'(1)] <= push_d1;
    end
  end

endmodule

// ----- rtl/go_back_n_state_table_top.sv -----
// go_back_n_state_table_top: per-slot go-back-n sequence state in one memory
// depends on gbn_pkg and gbn_outq
//
// Use: an input beat (in_valid/in_stall) carries one function: a received
// packet, a send request, a send finished, a timeout or a slot init. Each
// beat gives zero, one or two result beats on out_valid/out_stall; out_last
// marks the final result of a beat. Write the window limit through cfg_wr_en
// and cfg_wr_data while the block is idle; it resets to 16.
// Each beat is read, then executed: the slot entry is read from the state
// memory into a registered read port, then the execute state updates it,
// writes it back and pushes the results. A new beat is taken only once the
// last one has executed and while the result queue (four entries) has room
// for two more results; the first result shows on out_valid once pushed.
// After reset the block sweeps the state memory to zero, one slot a cycle,
// over all SLOTS slots (64 by default), holding in_stall high until it ends.
// When the receiver stalls, results stay in the queue with stable payload;
// once fewer than two entries are free, in_stall rises.
module go_back_n_state_table_top import gbn_pkg::*; #(
  parameter int SLOTS     = 64,
  parameter int SEQ_BITS  = 32,
  parameter int SLOT_BITS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_wr_en,
  input  logic [WIN_W-1:0]     cfg_wr_data,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [SLOT_BITS-1:0] in_slot,
  input  logic [TYPE_W-1:0]    in_pkt_type,
  input  logic [SLOT_BITS-1:0] in_peer_slot,
  input  logic [SEQ_BITS-1:0]  in_seq,
  input  logic [IP_W-1:0]      in_pkt_src_ip,
  input  logic [IP_W-1:0]      in_pkt_dest_ip,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    out_kind,
  output logic [SLOT_BITS-1:0] out_slot,
  output logic [SLOT_BITS-1:0] out_peer_slot,
  output logic [SEQ_BITS-1:0]  out_seq_first,
  output logic [SEQ_BITS-1:0]  out_seq_last,
  output logic                 out_flag,
  output logic [IP_W-1:0]      out_reply_dest_ip,
  output logic [IP_W-1:0]      out_reply_src_ip,
  output logic                 out_last
);

  localparam int IDX_W     = $clog2(SLOTS);
  localparam int MOD_STEPS = (SLOT_BITS >= IDX_W) ? (SLOT_BITS - IDX_W + 1) : 1;
  localparam int MW        = SLOT_BITS + IDX_W + 1;
  localparam int ENT_W     = 3 * SEQ_BITS + 1;
  localparam int CW        = (SEQ_BITS > WIN_W) ? SEQ_BITS : WIN_W;
  localparam int RES_W     = KIND_W + 2 * SLOT_BITS + 2 * SEQ_BITS + 1 + 2 * IP_W + 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  function automatic logic [IDX_W-1:0] slot_mod(input logic [SLOT_BITS-1:0] v);
    logic [MW-1:0] r;
    r = MW'(v);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (r >= (MW'(SLOTS) << k)) r = r - (MW'(SLOTS) << k);
    end
    return r[IDX_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] mk_res(
    input logic [KIND_W-1:0]    kind,
    input logic [SLOT_BITS-1:0] oslot,
    input logic [SLOT_BITS-1:0] peer,
    input logic [SEQ_BITS-1:0]  first,
    input logic [SEQ_BITS-1:0]  lastq,
    input logic                 flag,
    input logic [IP_W-1:0]      dip,
    input logic [IP_W-1:0]      sip
  );
    return {kind, oslot, peer, first, lastq, flag, dip, sip, 1'b0};
  endfunction

  // control
  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    clr_cnt_r;
  logic [WIN_W-1:0]    window_r;
  logic                accept;
  logic [Q_CNT_W-1:0]  q_cnt;

  // latched input beat
  logic [FUNC_W-1:0]    func_r;
  logic [SLOT_BITS-1:0] rslot_r;
  logic [TYPE_W-1:0]    type_r;
  logic [SLOT_BITS-1:0] peer_r;
  logic [SEQ_BITS-1:0]  seq_r;
  logic [IP_W-1:0]      sip_r;
  logic [IP_W-1:0]      dip_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     addr_r;

  // send in progress
  logic                 send_busy_r, send_busy_nxt;
  logic [IDX_W-1:0]     send_slot_r, send_slot_nxt;
  logic [SEQ_BITS-1:0]  send_acked_r, send_acked_nxt;
  logic [SEQ_BITS-1:0]  send_sent_r, send_sent_nxt;

  // state memory: {ack_en, expected, acked, sent}
  logic [ENT_W-1:0]     mem_r [SLOTS];
  logic [ENT_W-1:0]     rd_data_r;
  logic [IDX_W-1:0]     in_idx;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [ENT_W-1:0]     mem_wd;

  // execute
  logic                 e_aen;
  logic [SEQ_BITS-1:0]  e_exp, e_acked, e_sent;
  logic                 n_aen;
  logic [SEQ_BITS-1:0]  n_exp, n_acked, n_sent;
  logic [SEQ_BITS-1:0]  diff;
  logic                 room;
  logic                 retrans;
  logic [1:0]           res_n;
  logic [RES_W-1:0]     res0, res1;
  logic [1:0]           push_n;
  logic [RES_W-1:0]     push_d0, push_d1;
  logic [RES_W-1:0]     q_head;

  assign in_idx   = slot_mod(in_slot);
  assign in_stall = !((state_r == S_IDLE) && (q_cnt <= Q_CNT_W'(Q_DEPTH - 2)));
  assign accept   = in_valid && !in_stall;
  assign rd_addr  = (in_func == FUNC_SEND_DONE) ? send_slot_r : in_idx;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == IDX_W'(SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      window_r     <= WIN_RESET;
      send_busy_r  <= 1'b0;
      send_slot_r  <= '0;
      send_acked_r <= '0;
      send_sent_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (cfg_wr_en) window_r <= cfg_wr_data;
      send_busy_r  <= send_busy_nxt;
      send_slot_r  <= send_slot_nxt;
      send_acked_r <= send_acked_nxt;
      send_sent_r  <= send_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      rslot_r <= in_slot;
      type_r  <= in_pkt_type;
      peer_r  <= in_peer_slot;
      seq_r   <= in_seq;
      sip_r   <= in_pkt_src_ip;
      dip_r   <= in_pkt_dest_ip;
      idx_r   <= in_idx;
      addr_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    rd_data_r <= mem_r[rd_addr];
  end

  assign {e_aen, e_exp, e_acked, e_sent} = rd_data_r;
  assign diff = e_sent - e_acked;
  assign room = (e_sent < e_acked) || (CW'(diff) < CW'(window_r));

  always_comb begin
    n_aen          = e_aen;
    n_exp          = e_exp;
    n_acked        = e_acked;
    n_sent         = e_sent;
    send_busy_nxt  = send_busy_r;
    send_slot_nxt  = send_slot_r;
    send_acked_nxt = send_acked_r;
    send_sent_nxt  = send_sent_r;
    retrans        = 1'b0;
    res_n          = 2'd0;
    res0           = '0;
    res1           = '0;
    case (func_r)
      FUNC_RX: begin
        if (type_r == PKT_DATA) begin
          if (seq_r == e_exp) begin
            n_exp = e_exp + SEQ_BITS'(1);
            n_aen = 1'b1;
            res0  = mk_res(KIND_REPLY, rslot_r, peer_r, e_exp, '0, 1'b0, sip_r, dip_r);
            res1  = mk_res(KIND_QUERY, rslot_r, '0, '0, '0, 1'b1, '0, '0);
            res_n = 2'd2;
          end else if (e_aen) begin
            if (seq_r > e_exp) n_aen = 1'b0;
            res0  = mk_res(KIND_REPLY, rslot_r, peer_r, e_exp - SEQ_BITS'(1), '0,
                           seq_r > e_exp, sip_r, dip_r);
            res1  = mk_res(KIND_QUERY, rslot_r, '0, '0, '0, 1'b0, '0, '0);
            res_n = 2'd2;
          end else begin
            res0  = mk_res(KIND_QUERY, rslot_r, '0, '0, '0, 1'b0, '0, '0);
            res_n = 2'd1;
          end
        end else if (type_r == PKT_ACK || type_r == PKT_NACK) begin
          res0  = mk_res(KIND_QUERY, rslot_r, '0, '0, '0, 1'b0, '0, '0);
          res_n = 2'd1;
          if (seq_r > e_acked) begin
            n_acked = seq_r;
            if (seq_r == e_sent) begin
              res1  = mk_res(KIND_TIMER, rslot_r, '0, '0, '0, 1'b1, '0, '0);
              res_n = 2'd2;
            end else if (type_r == PKT_ACK) begin
              res1  = mk_res(KIND_TIMER, rslot_r, '0, '0, '0, 1'b0, '0, '0);
              res_n = 2'd2;
            end else begin
              retrans = 1'b1;
            end
          end else if (seq_r == e_acked && type_r == PKT_NACK) begin
            retrans = 1'b1;
          end
          if (retrans) begin
            res1  = mk_res(KIND_RETRANS, rslot_r, '0, seq_r + SEQ_BITS'(1), e_sent,
                           1'b0, '0, '0);
            res_n = 2'd2;
          end
        end else begin
          res0  = mk_res(KIND_QUERY, rslot_r, '0, '0, '0,
                         (type_r == PKT_SYN) || (type_r == PKT_FIN), '0, '0);
          res_n = 2'd1;
        end
      end
      FUNC_SEND_REQ: begin
        if (!send_busy_r && room) begin
          send_busy_nxt  = 1'b1;
          send_slot_nxt  = idx_r;
          send_acked_nxt = e_acked;
          send_sent_nxt  = e_sent;
          res0 = mk_res(KIND_GRANT, rslot_r, '0, e_sent + SEQ_BITS'(1), '0, 1'b0, '0, '0);
        end else begin
          res0 = mk_res(KIND_REFUSE, rslot_r, '0, '0, '0, 1'b0, '0, '0);
        end
        res_n = 2'd1;
      end
      FUNC_SEND_DONE: begin
        // entry read at the held send slot, not the beat's slot
        if (send_busy_r) begin
          if (send_acked_r == send_sent_r) begin
            res0  = mk_res(KIND_TIMER, SLOT_BITS'(send_slot_r), '0, '0, '0, 1'b0,
                           '0, '0);
            res_n = 2'd1;
          end
          n_sent        = send_sent_r + SEQ_BITS'(1);
          send_busy_nxt = 1'b0;
        end
      end
      FUNC_TIMEOUT: begin
        res0  = mk_res(KIND_RETRANS, rslot_r, '0, e_acked + SEQ_BITS'(1), e_sent,
                       1'b0, '0, '0);
        res_n = 2'd1;
      end
      FUNC_INIT: begin
        n_aen   = 1'b1;
        n_exp   = SEQ_BITS'(1);
        n_acked = '0;
        n_sent  = '0;
      end
      default: begin
        res_n = 2'd0;
      end
    endcase
    if (state_r != S_EXEC) begin
      send_busy_nxt  = send_busy_r;
      send_slot_nxt  = send_slot_r;
      send_acked_nxt = send_acked_r;
      send_sent_nxt  = send_sent_r;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = {n_aen, n_exp, n_acked, n_sent};
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else if (state_r == S_EXEC) begin
      mem_we = 1'b1;
    end
  end

  // last flag rides on the final result of the beat
  assign push_n  = (state_r == S_EXEC) ? res_n : 2'd0;
  assign push_d0 = {res0[RES_W-1:1], res_n == 2'd1};
  assign push_d1 = {res1[RES_W-1:1], 1'b1};

  gbn_outq #(
    .W (RES_W)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push_d0    (push_d0),
    .push_d1    (push_d1),
    .head       (q_head),
    .head_valid (out_valid),
    .pop        (!out_stall),
    .count      (q_cnt)
  );

  assign {out_kind, out_slot, out_peer_slot, out_seq_first, out_seq_last, out_flag,
          out_reply_dest_ip, out_reply_src_ip, out_last} = q_head;

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted beat did not enter execute");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> (q_cnt <= Q_CNT_W'(Q_DEPTH - 2)))
    else $error("result queue lacks room for two results");

  a_busy_by_grant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(send_busy_r) |-> $past((state_r == S_EXEC) && (func_r == FUNC_SEND_REQ)))
    else $error("send busy set without a send request");

  a_no_stall_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> (out_valid == 1'b0))
    else $error("result appeared during the clearing sweep");
`endif

endmodule
